@@ src/scfr_pkg.sv @@
// Shared types and constants of the sum-checked frame receiver.
package scfr_pkg;

  // Receive phases, one for each byte position of a frame.
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_CMD    = 3'd2,
    PH_LENHI  = 3'd3,
    PH_LENLO  = 3'd4,
    PH_PARAM  = 3'd5,
    PH_CHECK  = 3'd6,
    PH_END    = 3'd7
  } scfr_phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CHECKSUM  = 2'd1,
    ST_WRONG_TYP = 2'd2,
    ST_WRONG_CMD = 2'd3
  } scfr_status_e;

  typedef enum logic {
    KIND_PARAM  = 1'b0,
    KIND_STATUS = 1'b1
  } scfr_kind_e;

  // Register indexes on the configuration port.
  localparam logic REG_EXP_TYPE = 1'b0;
  localparam logic REG_EXP_CMD  = 1'b1;

  localparam logic [7:0] EXP_TYPE_RESET = 8'h01;
  localparam logic [7:0] EXP_CMD_RESET  = 8'h03;

  typedef struct packed {
    logic [7:0] exp_type;
    logic [7:0] exp_command;
  } scfr_cfg_t;

  typedef struct packed {
    scfr_kind_e   kind;
    logic [7:0]   payload;
    scfr_status_e status;
    logic [7:0]   command;
    logic [15:0]  length;
  } scfr_result_t;

endpackage

@@ src/scfr_cfg_regs.sv @@
// APB-style configuration registers holding the expected type and command.
module scfr_cfg_regs import scfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output scfr_cfg_t   cfg_o
);

  logic [7:0] exp_type_q, exp_type_d;
  logic [7:0] exp_cmd_q, exp_cmd_d;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    exp_type_d = exp_type_q;
    exp_cmd_d  = exp_cmd_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_EXP_TYPE: exp_type_d = pwdata[7:0];
        REG_EXP_CMD:  exp_cmd_d  = pwdata[7:0];
        default:      exp_type_d = exp_type_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXP_TYPE: prdata = {24'd0, exp_type_q};
      REG_EXP_CMD:  prdata = {24'd0, exp_cmd_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= EXP_TYPE_RESET;
      exp_cmd_q  <= EXP_CMD_RESET;
    end else begin
      exp_type_q <= exp_type_d;
      exp_cmd_q  <= exp_cmd_d;
    end
  end

  assign cfg_o.exp_type    = exp_type_q;
  assign cfg_o.exp_command = exp_cmd_q;

endmodule

@@ src/scfr_parser.sv @@
// Frame parser: phase tracking, length counting, checksum and status decision.
module scfr_parser import scfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  input  scfr_cfg_t    cfg_i,
  output logic         res_valid_o,
  output scfr_result_t res_o
);

  scfr_phase_e  phase_q, phase_d;
  logic [15:0]  count_q, count_d;
  logic [15:0]  len_q, len_d;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   type_q, type_d;
  logic [7:0]   cmd_q, cmd_d;
  logic [7:0]   chk_q, chk_d;
  logic [7:0]   sum_add;
  logic [15:0]  count_inc;
  logic [15:0]  len_full;
  scfr_status_e status;

  assign sum_add   = sum_q + rx_byte_i;
  assign count_inc = count_q + 16'd1;
  assign len_full  = {len_q[15:8], rx_byte_i};

  // Next state.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    sum_d   = sum_q;
    type_d  = type_q;
    cmd_d   = cmd_q;
    chk_d   = chk_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_HEADER: phase_d = PH_TYPE;
        PH_TYPE: begin
          type_d  = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d   = {rx_byte_i, 8'h00};
          sum_d   = sum_add;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          len_d   = len_full;
          sum_d   = sum_add;
          count_d = 16'd0;
          // A frame without parameters goes straight to its checksum byte.
          phase_d = (len_full == 16'd0) ? PH_CHECK : PH_PARAM;
        end
        PH_PARAM: begin
          sum_d   = sum_add;
          count_d = count_inc;
          if (count_inc == len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          chk_d   = rx_byte_i;
          phase_d = PH_END;
        end
        PH_END:  phase_d = PH_HEADER;
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  // The first fault in check order wins.
  always_comb begin
    priority if (chk_q != sum_q) begin
      status = ST_CHECKSUM;
    end else if (type_q != cfg_i.exp_type) begin
      status = ST_WRONG_TYP;
    end else if (cmd_q != cfg_i.exp_command) begin
      status = ST_WRONG_CMD;
    end else begin
      status = ST_OK;
    end
  end

  // Outputs.
  always_comb begin
    res_valid_o   = 1'b0;
    res_o.kind    = KIND_PARAM;
    res_o.payload = 8'd0;
    res_o.status  = ST_OK;
    res_o.command = 8'd0;
    res_o.length  = 16'd0;
    unique case (phase_q)
      PH_PARAM: begin
        res_valid_o   = accept_i;
        res_o.payload = rx_byte_i;
      end
      PH_END: begin
        res_valid_o   = accept_i;
        res_o.kind    = KIND_STATUS;
        res_o.status  = status;
        res_o.command = cmd_q;
        res_o.length  = len_q;
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= 16'd0;
      len_q   <= 16'd0;
      sum_q   <= 8'd0;
      type_q  <= 8'd0;
      cmd_q   <= 8'd0;
      chk_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      cmd_q   <= cmd_d;
      chk_q   <= chk_d;
    end
  end

endmodule

@@ src/scfr_out_buf.sv @@
// Output register with a skid stage between the parser and the result channel.
module scfr_out_buf import scfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  scfr_result_t push_data_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output scfr_result_t out_data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  scfr_result_t out_data_q, out_data_d;
  scfr_result_t skid_data_q, skid_data_d;
  logic         pop;

  assign pop     = out_valid_q && out_ready_i;
  // Input may be taken as long as the skid stage is free.
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_data_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/sum_checked_frame_receiver_top.sv @@
// Top level of the sum-checked frame receiver.
//
// Received bytes enter on the input channel (rx_byte_i, in_valid_i/in_ready_o),
// one per beat. A frame is header, type, command, two big-endian length bytes,
// that many parameter bytes, a checksum byte and an end byte. Each parameter
// byte leaves on the result channel as a beat with item_kind 0. The end byte
// gives one status beat with item_kind 1, carrying the frame status, command
// and length; the consumer drops the payload of a frame whose status is not ok.
// Other bytes produce no result beat.
// Every input byte is handled in the cycle it is accepted and its result is
// registered. One byte per cycle is sustained; the only limit is the output
// register plus a one-entry skid stage, so input stalls after two results wait
// unread. Expected type and command are written over the APB port (byte
// addresses 0 and 4) while the block is idle, which the user must ensure; the
// block does not enforce it. Reset returns the parser to the header byte,
// empties the output stages and loads type 1 and command 3.
module sum_checked_frame_receiver_top import scfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  frame_command_o,
  output logic [15:0] frame_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scfr_cfg_t    cfg;
  scfr_result_t res;
  scfr_result_t out_data;
  logic         res_valid;
  logic         space;
  logic         accept;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  scfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scfr_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign item_kind_o     = out_data.kind;
  assign payload_byte_o  = out_data.payload;
  assign frame_status_o  = out_data.status;
  assign frame_command_o = out_data.command;
  assign frame_length_o  = out_data.length;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the sum-checked frame receiver top level.
module tb import scfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic [7:0]  rx_byte;
  logic        in_valid;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [1:0]  frame_status;
  logic [7:0]  frame_command;
  logic [15:0] frame_length;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Receiver state as tracked by the testbench.
  scfr_phase_e rx_phase;
  logic [15:0] rx_count;
  logic [15:0] rx_len;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_type;
  logic [7:0]  rx_cmd;
  logic [7:0]  rx_chk;
  scfr_cfg_t   cfg_model;

  scfr_result_t pending_results[$];
  scfr_result_t want;
  int           mismatches;
  int           bytes_sent;
  int           cycles;
  int           out_wait;
  bit           pace_on;

  sum_checked_frame_receiver_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .rx_byte_i       (rx_byte),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .item_kind_o     (item_kind),
    .payload_byte_o  (payload_byte),
    .frame_status_o  (frame_status),
    .frame_command_o (frame_command),
    .frame_length_o  (frame_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Advances the tracked parser by one accepted byte and queues what it yields.
  function automatic void track_rx_byte(logic [7:0] b);
    scfr_result_t r;
    r = '0;
    case (rx_phase)
      PH_HEADER: begin
        rx_phase = PH_TYPE;
      end
      PH_TYPE: begin
        rx_type  = b;
        rx_sum   = b;
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        rx_cmd   = b;
        rx_sum   = rx_sum + b;
        rx_phase = PH_LENHI;
      end
      PH_LENHI: begin
        rx_len   = {b, 8'h00};
        rx_sum   = rx_sum + b;
        rx_phase = PH_LENLO;
      end
      PH_LENLO: begin
        rx_len[7:0] = b;
        rx_sum      = rx_sum + b;
        rx_count    = '0;
        rx_phase    = (rx_len == 16'd0) ? PH_CHECK : PH_PARAM;
      end
      PH_PARAM: begin
        rx_sum   = rx_sum + b;
        rx_count = rx_count + 16'd1;
        if (rx_count == rx_len) rx_phase = PH_CHECK;
        r.kind    = KIND_PARAM;
        r.payload = b;
        pending_results.push_back(r);
      end
      PH_CHECK: begin
        rx_chk   = b;
        rx_phase = PH_END;
      end
      default: begin
        r.kind = KIND_STATUS;
        if (rx_chk != rx_sum) r.status = ST_CHECKSUM;
        else if (rx_type != cfg_model.exp_type) r.status = ST_WRONG_TYP;
        else if (rx_cmd != cfg_model.exp_command) r.status = ST_WRONG_CMD;
        else r.status = ST_OK;
        r.command = rx_cmd;
        r.length  = rx_len;
        pending_results.push_back(r);
        rx_phase = PH_HEADER;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (pace_on && $urandom_range(0, 1) != 0) ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    // A gap drops valid first; valid and data only rise at a later falling edge.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] mark, input logic [7:0] f_type,
                            input logic [7:0] f_cmd, input logic [15:0] f_len,
                            input bit corrupt_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = f_type + f_cmd + f_len[15:8] + f_len[7:0];
    send_byte(mark);
    send_byte(f_type);
    send_byte(f_cmd);
    send_byte(f_len[15:8]);
    send_byte(f_len[7:0]);
    for (int i = 0; i < int'(f_len); i++) begin
      b   = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (corrupt_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
    send_byte(~mark);
  endtask

  // Drops valid and waits until every queued result has been seen.
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic idx, input logic [7:0] data,
                            output logic [7:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, data};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata[7:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic idx, input logic [7:0] value);
    logic [7:0] rd;
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_EXP_TYPE) cfg_model.exp_type = value;
    else cfg_model.exp_command = value;
    apb_access(1'b0, idx, 8'h00, rd);
    check_field("config readback", 16'(value), 16'(rd));
  endtask

  task automatic set_config(input logic [7:0] exp_t, input logic [7:0] exp_c);
    await_idle();
    write_config(REG_EXP_TYPE, exp_t);
    write_config(REG_EXP_CMD, exp_c);
  endtask

  // Reset settings: clean frame, then each fault and the fault priorities.
  task automatic test_directed_faults();
    send_frame(8'hFF, EXP_TYPE_RESET, EXP_CMD_RESET, 16'd0, 1'b0);
    send_frame(8'h00, 8'hFF, 8'h00, 16'd1, 1'b1);
    send_frame(8'h5A, 8'h00, 8'hFF, 16'd0, 1'b0);
    send_frame(8'hA5, EXP_TYPE_RESET, 8'h00, 16'd0, 1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(8'hFF, 8'h00);
    send_frame(8'h00, 8'hFF, 8'h00, 16'd2, 1'b0);
    set_config(8'h00, 8'hFF);
    send_frame(8'hFF, 8'h00, 8'hFF, 16'd1, 1'b0);
  endtask

  // A length with a nonzero high byte, run back to back on both sides.
  task automatic test_longest_frame();
    await_idle();
    pace_on = 1'b0;
    send_frame(8'h3C, cfg_model.exp_type, cfg_model.exp_command, 16'h0100, 1'b0);
    await_idle();
    pace_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int pick;
    int n;
    int goal;
    logic [7:0] f_type;
    logic [7:0] f_cmd;
    logic [15:0] f_len;
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: set_config(8'h00, 8'hFF);
        1: set_config(8'hFF, 8'h00);
        default: set_config(8'($urandom), 8'($urandom));
      endcase
      pace_on = (round != 1);
      goal = bytes_sent + 200;
      while (bytes_sent < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          // Noise burst, then junk until the parser is back at a header. The
          // high length byte is kept tiny so a desynced frame stays short.
          n = $urandom_range(1, 20);
          for (int i = 0; i < n || rx_phase != PH_HEADER; i++)
            send_byte((rx_phase == PH_LENHI) ? 8'($urandom_range(0, 1)) : 8'($urandom));
        end else if (pick == 2) begin
          await_idle();
        end else begin
          f_type = ($urandom_range(0, 3) != 0) ? cfg_model.exp_type : 8'($urandom);
          f_cmd  = ($urandom_range(0, 3) != 0) ? cfg_model.exp_command : 8'($urandom);
          f_len  = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 12))
                                               : 16'($urandom_range(13, 300));
          send_frame(8'($urandom), f_type, f_cmd, f_len, $urandom_range(0, 6) == 0);
        end
      end
    end
    pace_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat expected none actual kind %0h payload %0h status %0h",
                 $time, item_kind, payload_byte, frame_status);
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", 16'(want.kind), 16'(item_kind));
        check_field("payload_byte", 16'(want.payload), 16'(payload_byte));
        check_field("frame_status", 16'(want.status), 16'(frame_status));
        check_field("frame_command", 16'(want.command), 16'(frame_command));
        check_field("frame_length", want.length, frame_length);
      end
      out_wait = (pace_on && $urandom_range(0, 1) != 0) ? $urandom_range(0, 13) : 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    rx_byte   = 8'h00;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rx_phase  = PH_HEADER;
    rx_count  = '0;
    rx_len    = '0;
    rx_sum    = '0;
    rx_type   = '0;
    rx_cmd    = '0;
    rx_chk    = '0;
    cfg_model = {EXP_TYPE_RESET, EXP_CMD_RESET};
    mismatches = 0;
    bytes_sent = 0;
    cycles     = 0;
    out_wait   = 0;
    pace_on    = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_faults();
    test_config_extremes();
    test_longest_frame();
    test_random_frames();

    await_idle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/scfr_pkg.sv
src/scfr_cfg_regs.sv
src/scfr_parser.sv
src/scfr_out_buf.sv
src/sum_checked_frame_receiver_top.sv
tb/sv/tb.sv
